[hdl/tcwc_pkg.sv]
// Shared types, constants and the microcode ROM of the congestion window controller.
package tcwc_pkg;

  localparam int WINDOW_BITS_DEF = 24;
  localparam int TIME_BITS_DEF   = 32;

  localparam int SEQ_W   = 24;
  localparam int RTT_W   = 32;
  localparam int DELAY_W = 40;
  localparam int WGT_W   = 9;
  localparam int OFS_W   = 16;
  localparam int ADDR_W  = 4;

  localparam logic [RTT_W-1:0]   RTT_MAX   = '1;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
  localparam logic [WGT_W-1:0]   WGT_ONE   = 9'd256;

  // register reset values
  localparam logic [SEQ_W-1:0] FLOW_SIZE_RST   = 24'd1024;
  localparam logic [WGT_W-1:0] EWMA_WEIGHT_RST = 9'd224;
  localparam logic [OFS_W-1:0] RTT_OFFSET_RST  = 16'd0;
  localparam logic [RTT_W-1:0] RTT_INITIAL_RST = 32'd25600;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_FLOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_EWMA_WEIGHT = 2'd1;
  localparam logic [1:0] REG_RTT_OFFSET  = 2'd2;
  localparam logic [1:0] REG_RTT_INITIAL = 2'd3;

  // request opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    MODE_UNSET = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_VALUE = 2'd2
  } thresh_mode_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_START,
    ALU_PREP,
    ALU_DIVSTEP,
    ALU_SUM1,
    ALU_SUM2,
    ALU_GROW,
    ALU_TIMEOUT,
    ALU_SEND,
    ALU_EMIT,
    ALU_DONE
  } alu_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_ACKCHK,
    J_LOOP,
    J_OUT
  } jmp_e;

  typedef logic [3:0] upc_t;

  localparam upc_t UA_WAIT  = 4'd0;
  localparam upc_t UA_ACK   = 4'd1;
  localparam upc_t UA_PREP  = 4'd2;
  localparam upc_t UA_DIV   = 4'd3;
  localparam upc_t UA_SUM1  = 4'd4;
  localparam upc_t UA_SUM2  = 4'd5;
  localparam upc_t UA_GROW  = 4'd6;
  localparam upc_t UA_SEND  = 4'd7;
  localparam upc_t UA_EMIT  = 4'd8;
  localparam upc_t UA_START = 4'd9;
  localparam upc_t UA_TMO   = 4'd10;
  localparam upc_t UA_DONE  = 4'd11;

  typedef struct packed {
    alu_e op;
    jmp_e jmp;
    upc_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    case (addr)
      UA_WAIT:  w = '{op: ALU_NOP,     jmp: J_DISPATCH, target: UA_WAIT};
      UA_ACK:   w = '{op: ALU_NOP,     jmp: J_ACKCHK,   target: UA_WAIT};
      UA_PREP:  w = '{op: ALU_PREP,    jmp: J_NEXT,     target: UA_WAIT};
      UA_DIV:   w = '{op: ALU_DIVSTEP, jmp: J_LOOP,     target: UA_DIV};
      UA_SUM1:  w = '{op: ALU_SUM1,    jmp: J_NEXT,     target: UA_WAIT};
      UA_SUM2:  w = '{op: ALU_SUM2,    jmp: J_NEXT,     target: UA_WAIT};
      UA_GROW:  w = '{op: ALU_GROW,    jmp: J_NEXT,     target: UA_WAIT};
      UA_SEND:  w = '{op: ALU_SEND,    jmp: J_NEXT,     target: UA_WAIT};
      UA_EMIT:  w = '{op: ALU_EMIT,    jmp: J_OUT,      target: UA_WAIT};
      UA_START: w = '{op: ALU_START,   jmp: J_GOTO,     target: UA_SEND};
      UA_TMO:   w = '{op: ALU_TIMEOUT, jmp: J_GOTO,     target: UA_SEND};
      UA_DONE:  w = '{op: ALU_DONE,    jmp: J_OUT,      target: UA_WAIT};
      default:  w = '{op: ALU_NOP,     jmp: J_GOTO,     target: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hdl/tcp_congestion_window_control.sv]
// Congestion window controller: microcoded sequencer over a small arithmetic datapath.
// Start and timeout requests: a START or TMO step, then SEND and EMIT; EMIT loads the output register.
// Ack requests: ACK check, PREP, a one-bit-per-cycle restoring divide of the 9 + TIME_BITS bit
//   RTT sample by the window, then SUM1, SUM2, GROW, SEND and EMIT.
// One request in flight; the next is taken once the sequencer is back in its wait step.
// Async active-low reset loads register defaults, window 1, slow start, sequence 0.
module tcp_congestion_window_control #(
  parameter int WINDOW_BITS = tcwc_pkg::WINDOW_BITS_DEF,
  parameter int TIME_BITS   = tcwc_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [tcwc_pkg::SEQ_W-1:0]  acked_seq_i,
  input  logic [TIME_BITS-1:0]        now_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [tcwc_pkg::SEQ_W-1:0]  send_seq_o,
  output logic [tcwc_pkg::SEQ_W-1:0]  send_size_o,
  output logic [tcwc_pkg::DELAY_W-1:0] timeout_delay_o
);
  import tcwc_pkg::*;

  localparam int WB   = WINDOW_BITS;
  localparam int TB   = TIME_BITS;
  localparam int DIVW = WGT_W + TB;
  localparam int QW   = (DIVW > RTT_W) ? DIVW : RTT_W + 1;
  localparam int CNTW = $clog2(DIVW);
  localparam int CMPW = (WB > SEQ_W) ? WB : SEQ_W;
  localparam int PW   = RTT_W + WB;
  localparam int T1W  = WGT_W + RTT_W;

  localparam logic [WB-1:0]   WIN_MAX  = '1;
  localparam logic [WB-1:0]   WIN_ONE  = WB'(1);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DIVW - 1);

  // configuration registers
  logic [SEQ_W-1:0] flow_size_q;
  logic [WGT_W-1:0] ewma_weight_q;
  logic [OFS_W-1:0] rtt_offset_q;
  logic [RTT_W-1:0] rtt_initial_q;

  // architectural state
  logic [WB-1:0]    cwnd_q, cwnd_d;
  logic [WB-1:0]    thr_q, thr_d;
  thresh_mode_e     mode_q, mode_d;
  logic             ss_q, ss_d;
  logic [SEQ_W-1:0] rem_q, rem_d;
  logic [TB-1:0]    stime_q, stime_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [RTT_W-1:0] rtt_q, rtt_d;

  // sequencer
  upc_t   upc_q, upc_d;
  ucode_t uw;

  // work registers
  logic [SEQ_W-1:0] ack_q;
  logic [TB-1:0]    now_q;
  logic [RTT_W-1:0] t1_q, t1_d;
  logic [DIVW-1:0]  dvd_q, dvd_d;
  logic [WB-1:0]    rr_q, rr_d;
  logic [WB-1:0]    divr_q, divr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [PW-1:0]    mul_q, mul_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [SEQ_W-1:0]     oseq_q, oseq_d;
  logic [SEQ_W-1:0]     osize_q, osize_d;
  logic [DELAY_W-1:0]   odly_q, odly_d;

  logic in_fire, out_free, cfg_wr;

  // datapath intermediates
  logic [WGT_W-1:0] w_cap, w_inv;
  logic [TB-1:0]    elapsed;
  logic [T1W-1:0]   t1_prod;
  logic [T1W-9:0]   t1_sh;
  logic [WB:0]      trial;
  logic [QW-1:0]    q_ext;
  logic [RTT_W-1:0] q_sat;
  logic [RTT_W:0]   sum1, sum2;
  logic [WB:0]      grow;
  logic [WB-1:0]    grow_c;
  logic [PW-1:0]    mul_sh;

  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign in_ready_o  = (upc_q == UA_WAIT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign kind_o          = kind_q;
  assign send_seq_o      = oseq_q;
  assign send_size_o     = osize_q;
  assign timeout_delay_o = odly_q;

  always_comb begin
    case (paddr[3:2])
      REG_FLOW_SIZE:   prdata = 32'(flow_size_q);
      REG_EWMA_WEIGHT: prdata = 32'(ewma_weight_q);
      REG_RTT_OFFSET:  prdata = 32'(rtt_offset_q);
      REG_RTT_INITIAL: prdata = rtt_initial_q;
      default:         prdata = '0;
    endcase
  end

  assign uw = ucode_rom(upc_q);

  // arithmetic pieces
  assign w_cap   = (ewma_weight_q > WGT_ONE) ? WGT_ONE : ewma_weight_q;
  assign w_inv   = WGT_ONE - w_cap;
  assign elapsed = now_q - stime_q;
  assign t1_prod = T1W'(w_cap) * T1W'(rtt_q);
  assign t1_sh   = t1_prod[T1W-1:8];
  assign trial   = {rr_q, dvd_q[DIVW-1]};
  assign q_ext   = QW'(dvd_q);
  assign q_sat   = (q_ext > QW'(RTT_MAX)) ? RTT_MAX : q_ext[RTT_W-1:0];
  assign sum1    = (RTT_W+1)'(t1_q) + (RTT_W+1)'(q_sat);
  assign sum2    = (RTT_W+1)'(t1_q) + (RTT_W+1)'(rtt_offset_q);
  assign grow    = ss_q ? {cwnd_q, 1'b0} : ((WB+1)'(cwnd_q) + (WB+1)'(1));
  assign grow_c  = grow[WB] ? WIN_MAX : grow[WB-1:0];
  assign mul_sh  = mul_q >> 8;

  always_comb begin
    cwnd_d  = cwnd_q;
    thr_d   = thr_q;
    mode_d  = mode_q;
    ss_d    = ss_q;
    rem_d   = rem_q;
    stime_d = stime_q;
    seq_d   = seq_q;
    rtt_d   = rtt_q;
    t1_d    = t1_q;
    dvd_d   = dvd_q;
    rr_d    = rr_q;
    divr_d  = divr_q;
    cnt_d   = cnt_q;
    mul_d   = mul_q;
    kind_d  = kind_q;
    oseq_d  = oseq_q;
    osize_d = osize_q;
    odly_d  = odly_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    case (uw.op)
      ALU_START: begin
        cwnd_d = WIN_ONE;
        ss_d   = 1'b1;
        mode_d = MODE_UNSET;
        rem_d  = flow_size_q;
        rtt_d  = rtt_initial_q;
      end
      ALU_PREP: begin
        if (mode_q == MODE_UNSET) mode_d = MODE_ARMED;
        t1_d   = (t1_sh > (T1W-8)'(RTT_MAX)) ? RTT_MAX : t1_sh[RTT_W-1:0];
        dvd_d  = DIVW'(w_inv) * DIVW'(elapsed);
        rr_d   = '0;
        divr_d = (cwnd_q == '0) ? WIN_ONE : cwnd_q;
        cnt_d  = CNT_LAST;
      end
      ALU_DIVSTEP: begin
        // restoring divide, quotient bits shift in behind the dividend
        if (trial >= (WB+1)'(divr_q)) begin
          rr_d  = WB'(trial - (WB+1)'(divr_q));
          dvd_d = {dvd_q[DIVW-2:0], 1'b1};
        end else begin
          rr_d  = trial[WB-1:0];
          dvd_d = {dvd_q[DIVW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNTW'(1);
      end
      ALU_SUM1: begin
        t1_d  = sum1[RTT_W] ? RTT_MAX : sum1[RTT_W-1:0];
        rem_d = (CMPW'(rem_q) > CMPW'(cwnd_q)) ? SEQ_W'(CMPW'(rem_q) - CMPW'(cwnd_q)) : '0;
      end
      ALU_SUM2: begin
        rtt_d = sum2[RTT_W] ? RTT_MAX : sum2[RTT_W-1:0];
        if (mode_q == MODE_VALUE && cwnd_q >= thr_q) ss_d = 1'b0;
      end
      ALU_GROW: begin
        cwnd_d = (CMPW'(grow_c) > CMPW'(rem_q)) ? WB'(rem_q) : grow_c;
      end
      ALU_TIMEOUT: begin
        rtt_d = (rtt_q[RTT_W-1 -: 4] != '0) ? RTT_MAX : {rtt_q[RTT_W-5:0], 4'b0};
        if (mode_q == MODE_ARMED) begin
          thr_d  = cwnd_q;
          mode_d = MODE_VALUE;
        end
        if (cwnd_q != WIN_ONE) begin
          thr_d  = cwnd_q >> 1;
          mode_d = MODE_VALUE;
        end
        cwnd_d = WIN_ONE;
        ss_d   = 1'b1;
      end
      ALU_SEND: begin
        stime_d = now_q;
        seq_d   = seq_q + SEQ_W'(1);
        mul_d   = PW'(rtt_q) * PW'(cwnd_q);
      end
      ALU_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_SEND;
          oseq_d  = seq_q;
          osize_d = SEQ_W'(cwnd_q);
          odly_d  = (mul_sh > PW'(DELAY_MAX)) ? DELAY_MAX : mul_sh[DELAY_W-1:0];
        end
      end
      ALU_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_DONE;
          oseq_d  = '0;
          osize_d = '0;
          odly_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // next step
  always_comb begin
    upc_d = upc_q + upc_t'(1);
    case (uw.jmp)
      J_NEXT: upc_d = upc_q + upc_t'(1);
      J_GOTO: upc_d = uw.target;
      J_DISPATCH: begin
        upc_d = UA_WAIT;
        if (in_fire) begin
          case (op_i)
            OP_START:   upc_d = UA_START;
            OP_ACK:     upc_d = UA_ACK;
            OP_TIMEOUT: upc_d = UA_TMO;
            default:    upc_d = UA_WAIT;
          endcase
        end
      end
      J_ACKCHK: begin
        if (rem_q == '0)        upc_d = UA_DONE;
        else if (ack_q < seq_q) upc_d = uw.target;
        else                    upc_d = upc_q + upc_t'(1);
      end
      J_LOOP: upc_d = (cnt_q != '0) ? uw.target : upc_q + upc_t'(1);
      J_OUT:  upc_d = out_free ? uw.target : upc_q;
      default: upc_d = UA_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_size_q   <= FLOW_SIZE_RST;
      ewma_weight_q <= EWMA_WEIGHT_RST;
      rtt_offset_q  <= RTT_OFFSET_RST;
      rtt_initial_q <= RTT_INITIAL_RST;
      upc_q       <= UA_WAIT;
      out_valid_q <= 1'b0;
      cwnd_q  <= WIN_ONE;
      thr_q   <= '0;
      mode_q  <= MODE_UNSET;
      ss_q    <= 1'b1;
      rem_q   <= FLOW_SIZE_RST;
      stime_q <= '0;
      seq_q   <= '0;
      rtt_q   <= RTT_INITIAL_RST;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_FLOW_SIZE:   flow_size_q   <= pwdata[SEQ_W-1:0];
          REG_EWMA_WEIGHT: ewma_weight_q <= pwdata[WGT_W-1:0];
          REG_RTT_OFFSET:  rtt_offset_q  <= pwdata[OFS_W-1:0];
          REG_RTT_INITIAL: rtt_initial_q <= pwdata;
          default: ;
        endcase
      end
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      cwnd_q  <= cwnd_d;
      thr_q   <= thr_d;
      mode_q  <= mode_d;
      ss_q    <= ss_d;
      rem_q   <= rem_d;
      stime_q <= stime_d;
      seq_q   <= seq_d;
      rtt_q   <= rtt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ack_q <= acked_seq_i;
      now_q <= now_i;
    end
    t1_q    <= t1_d;
    dvd_q   <= dvd_d;
    rr_q    <= rr_d;
    divr_q  <= divr_d;
    cnt_q   <= cnt_d;
    mul_q   <= mul_d;
    kind_q  <= kind_d;
    oseq_q  <= oseq_d;
    osize_q <= osize_d;
    odly_q  <= odly_d;
  end

endmodule
